// ----- hdl/msr_pkg.sv -----
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types, command codes, mode codes and register map of the motor
// speed ramp controller.
// ----------------------------------------------------------------------------
`default_nettype none

package msr_pkg;

  localparam int unsigned MSR_SPEED_BITS = 16;

  // command codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;
  localparam logic [1:0] FUNC_ESTOP = 2'd3;

  // operating modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_FWD   = 3'd1;
  localparam logic [2:0] MODE_BACK  = 3'd2;
  localparam logic [2:0] MODE_ACCEL = 3'd3;
  localparam logic [2:0] MODE_DECEL = 3'd4;
  localparam logic [2:0] MODE_ESTOP = 3'd5;

  // register index, taken from paddr[2]
  localparam logic REG_RAMP_RATE = 1'b0;
  localparam logic REG_MAX_DUTY  = 1'b1;

  localparam logic [7:0]  RAMP_RATE_RST = 8'd10;
  localparam logic [14:0] MAX_DUTY_RST  = 15'd1023;

  typedef struct packed {
    logic [7:0]  ramp_rate;
    logic [14:0] max_duty;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] speed_request;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] present_speed;
    logic [14:0]        duty;
    logic               reverse;
    logic               coast_stop;
    logic               brake_stop;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/msr_cfg.sv -----
// ----------------------------------------------------------------------------
// msr_cfg
// APB-style configuration registers: ramp rate and speed limit.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output msr_pkg::cfg_t      cfg_o
);
  import msr_pkg::*;

  logic [7:0]  ramp_rate_q, ramp_rate_d;
  logic [14:0] max_duty_q, max_duty_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    ramp_rate_d = ramp_rate_q;
    max_duty_d  = max_duty_q;
    if (wr_en) begin
      case (paddr[2])
        REG_RAMP_RATE: begin
          // zero rate would stall a ramp forever
          ramp_rate_d = (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
        end
        REG_MAX_DUTY: begin
          max_duty_d = pwdata[14:0];
        end
        default: begin
          ramp_rate_d = ramp_rate_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_rate_q <= RAMP_RATE_RST;
      max_duty_q  <= MAX_DUTY_RST;
    end else begin
      ramp_rate_q <= ramp_rate_d;
      max_duty_q  <= max_duty_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RAMP_RATE: prdata = {24'd0, ramp_rate_q};
      REG_MAX_DUTY:  prdata = {17'd0, max_duty_q};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o.ramp_rate = ramp_rate_q;
  assign cfg_o.max_duty  = max_duty_q;

endmodule

`default_nettype wire

// ----- hdl/msr_ctrl.sv -----
// ----------------------------------------------------------------------------
// msr_ctrl
// Mode, direction, target and speed registers with the per-command
// next-state logic; produces one result per executed command.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_ctrl #(
  parameter int unsigned SPEED_BITS = msr_pkg::MSR_SPEED_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire msr_pkg::cmd_t cmd_i,
  input  wire msr_pkg::cfg_t cfg_i,
  output msr_pkg::res_t      res_o
);
  import msr_pkg::*;

  localparam int unsigned SW = SPEED_BITS;
  // wide enough for the request, the limit and an overshooting ramp sum
  localparam int unsigned WW = ((SW > 16) ? SW : 16) + 2;
  localparam logic signed [WW-1:0] SpeedCap = WW'((longint'(1) << (SW - 1)) - 1);

  logic [2:0]           mode_q, mode_d;
  logic                 dir_q, dir_d;
  logic signed [SW-1:0] target_q, target_d;
  logic signed [SW-1:0] speed_q, speed_d;

  logic signed [WW-1:0] spd_w, tgt_w, rate_w, md_w, lim_w, req_w, clip_w;
  logic signed [WW-1:0] up_w, dn_w, up_cl, dn_cl, spd_n, tgt_n, spd_abs;
  logic [2:0]           mode_n, run_mode;
  logic                 dir_n, coast, brake;

  function automatic logic signed [WW-1:0] abs_w(input logic signed [WW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  always_comb begin
    spd_w  = WW'(speed_q);
    tgt_w  = WW'(target_q);
    rate_w = $signed(WW'(cfg_i.ramp_rate));
    md_w   = $signed(WW'(cfg_i.max_duty));
    lim_w  = (md_w < SpeedCap) ? md_w : SpeedCap;
    req_w  = WW'($signed(cmd_i.speed_request));
    clip_w = (req_w > lim_w) ? lim_w : ((req_w < -lim_w) ? -lim_w : req_w);
    up_w   = spd_w + rate_w;
    dn_w   = spd_w - rate_w;
    up_cl  = (up_w > tgt_w) ? tgt_w : up_w;
    dn_cl  = (dn_w < tgt_w) ? tgt_w : dn_w;
    run_mode = dir_q ? MODE_BACK : MODE_FWD;

    mode_n = mode_q;
    dir_n  = dir_q;
    tgt_n  = tgt_w;
    spd_n  = spd_w;
    coast  = 1'b0;
    brake  = 1'b0;

    case (cmd_i.func)
      FUNC_TICK: begin
        case (mode_q)
          MODE_ACCEL: begin
            if (abs_w(spd_w) < abs_w(tgt_w)) begin
              spd_n = (tgt_w > 0) ? up_cl : dn_cl;
              if (spd_n == tgt_w) mode_n = run_mode;
            end
          end
          MODE_DECEL: begin
            if (spd_w != tgt_w) begin
              spd_n = (spd_w > 0) ? dn_cl : up_cl;
              if (spd_n == 0) begin
                coast  = 1'b1;
                mode_n = MODE_IDLE;
              end else if (spd_n == tgt_w) begin
                mode_n = run_mode;
              end
            end
          end
          MODE_FWD, MODE_BACK: begin
            if (spd_w != tgt_w) begin
              mode_n = (abs_w(spd_w) < abs_w(tgt_w)) ? MODE_ACCEL : MODE_DECEL;
            end
          end
          default: begin
            mode_n = mode_q;
          end
        endcase
      end
      FUNC_SET: begin
        tgt_n = clip_w;
        if (clip_w > 0) dir_n = 1'b0;
        else if (clip_w < 0) dir_n = 1'b1;
        if (clip_w != 0) begin
          if (spd_w == 0) mode_n = MODE_ACCEL;
          else if (abs_w(clip_w) < abs_w(spd_w)) mode_n = MODE_DECEL;
          else mode_n = dir_n ? MODE_BACK : MODE_FWD;
        end else begin
          // zero request keeps the direction and ramps down
          mode_n = MODE_DECEL;
        end
      end
      FUNC_STOP: begin
        tgt_n  = '0;
        spd_n  = '0;
        coast  = 1'b1;
        mode_n = MODE_IDLE;
      end
      FUNC_ESTOP: begin
        tgt_n  = '0;
        spd_n  = '0;
        brake  = 1'b1;
        mode_n = MODE_ESTOP;
      end
      default: begin
        mode_n = mode_q;
      end
    endcase

    spd_abs = abs_w(spd_n);

    mode_d   = fire_i ? mode_n : mode_q;
    dir_d    = fire_i ? dir_n : dir_q;
    target_d = fire_i ? tgt_n[SW-1:0] : target_q;
    speed_d  = fire_i ? spd_n[SW-1:0] : speed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      dir_q    <= 1'b0;
      target_q <= '0;
      speed_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      dir_q    <= dir_d;
      target_q <= target_d;
      speed_q  <= speed_d;
    end
  end

  assign res_o.mode          = mode_n;
  assign res_o.present_speed = spd_n[15:0];
  assign res_o.duty          = spd_abs[14:0];
  assign res_o.reverse       = dir_n;
  assign res_o.coast_stop    = coast;
  assign res_o.brake_stop    = brake;

  a_estop_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && cmd_i.func == FUNC_ESTOP |=>
      mode_q == MODE_ESTOP && speed_q == 0 && target_q == 0)
    else $error("emergency stop did not zero the speeds");

  a_idle_at_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> speed_q == 0)
    else $error("idle mode with nonzero speed");

  a_hold_when_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(mode_q) && $stable(speed_q) && $stable(target_q))
    else $error("state changed without a command");

endmodule

`default_nettype wire

// ----- hdl/motor_speed_ramp_fsm_core.sv -----
// ----------------------------------------------------------------------------
// motor_speed_ramp_fsm_core
// Motor speed ramp controller: commands in, one status beat out per command.
// ----------------------------------------------------------------------------
// Every command (tick, set speed, stop, emergency stop) yields exactly one
// result beat. The block takes one command per clock: a command sits in the
// input register, is executed against the state registers by combinational
// add, compare and clamp logic, and lands in the output register, from which
// the result beat is presented; the throughput is one beat per cycle while
// the output is not stalled.
// Registers: ramp_rate at byte address 0 (zero is stored as one) and
// max_duty at byte address 4; write them only while no command is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_ramp_fsm_core #(
  parameter int unsigned SPEED_BITS = msr_pkg::MSR_SPEED_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         func_i,
  input  wire logic signed [15:0] speed_request_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              mode_o,
  output logic signed [15:0]      present_speed_o,
  output logic [14:0]             duty_o,
  output logic                    reverse_o,
  output logic                    coast_stop_o,
  output logic                    brake_stop_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import msr_pkg::*;

  cfg_t cfg;
  cmd_t cmd_q;
  res_t res_q, res_d;
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, fire, in_acc;

  msr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msr_ctrl #(
    .SPEED_BITS (SPEED_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .cmd_i  (cmd_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // output register frees up in the cycle its beat is taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) in_valid_d = 1'b1;
    else if (fire) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (fire) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q.func          <= func_i;
      cmd_q.speed_request <= speed_request_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = res_q.mode;
  assign present_speed_o = res_q.present_speed;
  assign duty_o          = res_q.duty;
  assign reverse_o       = res_q.reverse;
  assign coast_stop_o    = res_q.coast_stop;
  assign brake_stop_o    = res_q.brake_stop;

endmodule

`default_nettype wire
